FILE: hdl/hsvhm_pkg.sv
`timescale 1ns / 1ps

package hsvhm_pkg;

	localparam int COUNT_BITS = 20;
	localparam int HUE_BINS   = 180;
	localparam int LEVEL_BINS = 256;
	localparam int MAX_BINS   = (HUE_BINS > LEVEL_BINS) ? HUE_BINS : LEVEL_BINS;

	localparam int FIELD_W = 8;
	localparam int HUE_AW  = $clog2(HUE_BINS);
	localparam int LVL_AW  = $clog2(LEVEL_BINS);

	localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};
	localparam logic [FIELD_W:0]      HUE_LIM   = (FIELD_W + 1)'(HUE_BINS);
	localparam logic [FIELD_W:0]      LVL_LIM   = (FIELD_W + 1)'(LEVEL_BINS);
	localparam logic [FIELD_W-1:0]    SCAN_LAST = FIELD_W'(MAX_BINS - 1);

endpackage

FILE: hdl/hsv_histogram_mode_finder.sv
// Counts hue, saturation and value of an HSV pixel stream into three histograms held in
// simple dual-port synchronous memories, and on the last pixel of a frame returns the most
// frequent bin of each channel (lowest index on ties, 0 for an empty histogram). Pixels with
// value zero are skipped, and counters saturate at their maximum. During a frame one pixel
// word is taken every cycle; a read-modify-write pipeline with one stage of forwarding keeps
// back-to-back pixels on the same bin exact. The pixel that closes a frame is followed by a
// scan of all 256 bins, one bin a cycle, that also clears the memories: in_stall stays high
// through the flush, scan, finish and load states, plus any time the previous result still
// waits on out_stall. After reset the scan runs once as a clearing sweep, with no result.
`timescale 1ns / 1ps

module hsv_histogram_mode_finder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [hsvhm_pkg::FIELD_W-1:0] hue,
	input  logic [hsvhm_pkg::FIELD_W-1:0] saturation,
	input  logic [hsvhm_pkg::FIELD_W-1:0] brightness,
	input  logic                          frame_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [hsvhm_pkg::FIELD_W-1:0] hue_mode,
	output logic [hsvhm_pkg::FIELD_W-1:0] sat_mode,
	output logic [hsvhm_pkg::FIELD_W-1:0] val_mode
);
	import hsvhm_pkg::*;

	typedef enum logic [4:0] {
		ST_RUN    = 5'b00001,
		ST_FLUSH  = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_FINISH = 5'b01000,
		ST_LOAD   = 5'b10000
	} state_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] cnt);
		sat_inc = (cnt == CNT_MAX) ? cnt : cnt + COUNT_BITS'(1);
	endfunction

	logic [COUNT_BITS-1:0] hue_mem [HUE_BINS];
	logic [COUNT_BITS-1:0] sat_mem [LEVEL_BINS];
	logic [COUNT_BITS-1:0] val_mem [LEVEL_BINS];

	state_t state_q, state_d;
	logic   report_q;

	logic [FIELD_W-1:0] scan_idx_q;
	logic               scan_hue_s1, scan_lvl_s1;
	logic [FIELD_W-1:0] scan_idx_s1;

	logic                  hue_we_s1, sat_we_s1, val_we_s1;
	logic [HUE_AW-1:0]     hue_wa_s1;
	logic [LVL_AW-1:0]     sat_wa_s1, val_wa_s1;
	logic                  hue_hit_q, sat_hit_q, val_hit_q;
	logic [COUNT_BITS-1:0] hue_fwd_q, sat_fwd_q, val_fwd_q;
	logic [COUNT_BITS-1:0] hue_rd_q, sat_rd_q, val_rd_q;

	logic [COUNT_BITS-1:0] hue_best_q, sat_best_q, val_best_q;
	logic [FIELD_W-1:0]    hue_where_q, sat_where_q, val_where_q;

	logic                  out_valid_q;
	logic [FIELD_W-1:0]    hue_mode_q, sat_mode_q, val_mode_q;

	logic                  accept, pix_on;
	logic                  hue_in, sat_in, val_in;
	logic                  scan_hue, scan_lvl;
	logic [HUE_AW-1:0]     hue_ra, hue_wa;
	logic [LVL_AW-1:0]     sat_ra, val_ra, sat_wa, val_wa;
	logic                  hue_we, sat_we, val_we;
	logic [COUNT_BITS-1:0] hue_wd, sat_wd, val_wd;
	logic [COUNT_BITS-1:0] hue_cur, sat_cur, val_cur;
	logic                  load_out;

	assign in_stall = (state_q != ST_RUN);
	assign accept   = in_valid && !in_stall;
	assign pix_on   = (brightness != '0);
	assign hue_in   = ({1'b0, hue} < HUE_LIM);
	assign sat_in   = ({1'b0, saturation} < LVL_LIM);
	assign val_in   = ({1'b0, brightness} < LVL_LIM);

	assign scan_hue = (state_q == ST_SCAN) && ({1'b0, scan_idx_q} < HUE_LIM);
	assign scan_lvl = (state_q == ST_SCAN) && ({1'b0, scan_idx_q} < LVL_LIM);

	assign hue_cur = hue_hit_q ? hue_fwd_q : hue_rd_q;
	assign sat_cur = sat_hit_q ? sat_fwd_q : sat_rd_q;
	assign val_cur = val_hit_q ? val_fwd_q : val_rd_q;

	always_comb begin
		hue_ra = '0;
		sat_ra = '0;
		val_ra = '0;
		if (scan_hue) begin
			hue_ra = scan_idx_q[HUE_AW-1:0];
		end else if (hue_in) begin
			hue_ra = hue[HUE_AW-1:0];
		end
		if (scan_lvl) begin
			sat_ra = scan_idx_q[LVL_AW-1:0];
			val_ra = scan_idx_q[LVL_AW-1:0];
		end else begin
			if (sat_in) begin
				sat_ra = saturation[LVL_AW-1:0];
			end
			if (val_in) begin
				val_ra = brightness[LVL_AW-1:0];
			end
		end
	end

	always_comb begin
		if (scan_hue) begin
			hue_we = 1'b1;
			hue_wa = scan_idx_q[HUE_AW-1:0];
			hue_wd = '0;
		end else begin
			hue_we = hue_we_s1;
			hue_wa = hue_wa_s1;
			hue_wd = sat_inc(hue_cur);
		end
		if (scan_lvl) begin
			sat_we = 1'b1;
			val_we = 1'b1;
			sat_wa = scan_idx_q[LVL_AW-1:0];
			val_wa = scan_idx_q[LVL_AW-1:0];
			sat_wd = '0;
			val_wd = '0;
		end else begin
			sat_we = sat_we_s1;
			val_we = val_we_s1;
			sat_wa = sat_wa_s1;
			val_wa = val_wa_s1;
			sat_wd = sat_inc(sat_cur);
			val_wd = sat_inc(val_cur);
		end
	end

	always_ff @(posedge clk) begin
		if (hue_we) begin
			hue_mem[hue_wa] <= hue_wd;
		end
		hue_rd_q <= hue_mem[hue_ra];
	end

	always_ff @(posedge clk) begin
		if (sat_we) begin
			sat_mem[sat_wa] <= sat_wd;
		end
		sat_rd_q <= sat_mem[sat_ra];
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_wa] <= val_wd;
		end
		val_rd_q <= val_mem[val_ra];
	end

	always_ff @(posedge clk) begin
		hue_wa_s1 <= hue_ra;
		sat_wa_s1 <= sat_ra;
		val_wa_s1 <= val_ra;
		hue_fwd_q <= hue_wd;
		sat_fwd_q <= sat_wd;
		val_fwd_q <= val_wd;
		hue_hit_q <= hue_we_s1 && (hue_wa_s1 == hue_ra);
		sat_hit_q <= sat_we_s1 && (sat_wa_s1 == sat_ra);
		val_hit_q <= val_we_s1 && (val_wa_s1 == val_ra);
		scan_idx_s1 <= scan_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_we_s1   <= 1'b0;
			sat_we_s1   <= 1'b0;
			val_we_s1   <= 1'b0;
			scan_hue_s1 <= 1'b0;
			scan_lvl_s1 <= 1'b0;
		end else begin
			hue_we_s1   <= accept && pix_on && hue_in;
			sat_we_s1   <= accept && pix_on && sat_in;
			val_we_s1   <= accept && pix_on && val_in;
			scan_hue_s1 <= scan_hue;
			scan_lvl_s1 <= scan_lvl;
		end
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				if (accept && frame_end) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_idx_q == SCAN_LAST) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (!report_q) begin
					state_d = ST_RUN;
				end else if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SCAN;
			report_q    <= 1'b0;
			scan_idx_q  <= '0;
			hue_best_q  <= '0;
			sat_best_q  <= '0;
			val_best_q  <= '0;
			hue_where_q <= '0;
			sat_where_q <= '0;
			val_where_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FLUSH) begin
				report_q    <= 1'b1;
				scan_idx_q  <= '0;
				hue_best_q  <= '0;
				sat_best_q  <= '0;
				val_best_q  <= '0;
				hue_where_q <= '0;
				sat_where_q <= '0;
				val_where_q <= '0;
			end else begin
				if (state_q == ST_SCAN) begin
					scan_idx_q <= scan_idx_q + FIELD_W'(1);
				end
				if (scan_hue_s1 && (hue_rd_q > hue_best_q)) begin
					hue_best_q  <= hue_rd_q;
					hue_where_q <= scan_idx_s1;
				end
				if (scan_lvl_s1 && (sat_rd_q > sat_best_q)) begin
					sat_best_q  <= sat_rd_q;
					sat_where_q <= scan_idx_s1;
				end
				if (scan_lvl_s1 && (val_rd_q > val_best_q)) begin
					val_best_q  <= val_rd_q;
					val_where_q <= scan_idx_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			hue_mode_q <= hue_where_q;
			sat_mode_q <= sat_where_q;
			val_mode_q <= val_where_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hue_mode  = hue_mode_q;
	assign sat_mode  = sat_mode_q;
	assign val_mode  = val_mode_q;

endmodule

FILE: hdl/hsvhm_checker.sv
`timescale 1ns / 1ps

module hsvhm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          frame_end,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [hsvhm_pkg::FIELD_W-1:0] hue_mode,
	input logic [hsvhm_pkg::FIELD_W-1:0] sat_mode,
	input logic [hsvhm_pkg::FIELD_W-1:0] val_mode
);
	import hsvhm_pkg::*;

	// A stalled result word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hue_mode) && $stable(sat_mode)
			&& $stable(val_mode))
		else $error("result word changed while stalled");

	// The word that closes a frame starts the scan, which holds off input.
	a_scan_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && frame_end |=> in_stall ##1 in_stall)
		else $error("input taken during end-of-frame scan");

	// A result only appears at the end of a scan.
	a_result_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared outside a scan");

	// The hue mode is always a real hue bin.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, hue_mode} < HUE_LIM))
		else $error("hue mode out of range");

endmodule

bind hsv_histogram_mode_finder hsvhm_checker u_hsvhm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.frame_end (frame_end),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.hue_mode  (hue_mode),
	.sat_mode  (sat_mode),
	.val_mode  (val_mode)
);
